### rtl/assert_macros.svh
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on i_clk, off while in reset
`define FRR_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on i_clk, off while in reset
`define FRR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/frr_pkg.sv
// package: types, codes and constants of the framed result receiver
`timescale 1ns / 1ps
`default_nettype none

package frr_pkg;

    localparam int PAYLOAD_BYTES_DEF = 28;
    localparam int NUM_WORDS         = 7;
    localparam int QUEUE_DEPTH       = 2;
    localparam int CFG_DATA_W        = 16;
    localparam int CFG_INDEX_W       = 2;

    localparam logic [15:0] TIMEOUT_RST = 16'd5000;
    localparam logic [7:0]  START_RST   = 8'hAA;
    localparam logic [7:0]  END_RST     = 8'h55;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_TIMEOUT = 2'd0,
        CFG_START   = 2'd1,
        CFG_END     = 2'd2
    } t_cfg_index;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_MODEL   = 2'd1,
        PH_PAYLOAD = 2'd2,
        PH_END     = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_START = 2'd1,
        ST_BAD_END   = 2'd2,
        ST_TIMEOUT   = 2'd3
    } t_status;

    typedef struct packed {
        logic       func;
        logic [7:0] rx_byte;
    } t_frr_in;

    typedef struct packed {
        t_status     status;
        logic [7:0]  model_code;
        logic [31:0] magnitude_bits;
        logic [31:0] phase_bits;
        logic [31:0] real_bits;
        logic [31:0] imag_bits;
        logic [31:0] drive_level_bits;
        logic [31:0] sense_level_bits;
        logic [31:0] fit_error_bits;
    } t_frr_out;

    // classified item handed from front to back
    typedef struct packed {
        logic       is_tick;
        logic       is_start;
        logic       is_end;
        logic [7:0] data;
    } t_cmd;

endpackage

`default_nettype wire

### rtl/frr_front.sv
// front end: accepts items, classifies them and queues them for the back end
`timescale 1ns / 1ps
`default_nettype none

module frr_front
    import frr_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_ready,
    input  wire t_frr_in i_in_data,
    input  wire logic [7:0] i_start_byte,
    input  wire logic [7:0] i_end_byte,
    output logic         o_cmd_valid,
    input  wire logic    i_cmd_ready,
    output t_cmd         o_cmd
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_cmd             r_q [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    t_cmd             w_cmd;
    logic             w_push;
    logic             w_pop;

    assign o_in_ready  = (r_count != CNT_W'(QUEUE_DEPTH));
    assign o_cmd_valid = (r_count != '0);
    assign o_cmd       = r_q[r_rd];
    assign w_push      = i_in_valid & o_in_ready;
    assign w_pop       = o_cmd_valid & i_cmd_ready;

    always_comb begin
        w_cmd.is_tick  = i_in_data.func;
        w_cmd.is_start = (i_in_data.rx_byte == i_start_byte);
        w_cmd.is_end   = (i_in_data.rx_byte == i_end_byte);
        w_cmd.data     = i_in_data.rx_byte;
    end

    always_comb begin
        n_count = r_count;
        if (w_push && !w_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (!w_push && w_pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_count <= n_count;
            if (w_push) begin
                r_wr <= (r_wr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
            end
            if (w_pop) begin
                r_rd <= (r_rd == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr] <= w_cmd;
        end
    end

endmodule

`default_nettype wire

### rtl/frr_back.sv
// back end: frame state machine, payload store and result register
`timescale 1ns / 1ps
`default_nettype none

module frr_back
    import frr_pkg::*;
#(
    parameter int PAYLOAD_BYTES = PAYLOAD_BYTES_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cmd_valid,
    output logic             o_cmd_ready,
    input  wire t_cmd        i_cmd,
    input  wire logic [15:0] i_timeout_ticks,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output t_frr_out         o_out_data
);

    localparam int CNT_W = $clog2(PAYLOAD_BYTES);

    t_phase           r_phase;
    t_phase           n_phase;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic [7:0]       r_model;
    logic [7:0]       n_model;
    logic [15:0]      r_ticks;
    logic [15:0]      n_ticks;
    logic [7:0]       r_payload [PAYLOAD_BYTES];
    logic             r_out_valid;
    t_frr_out         r_out;
    t_frr_out         n_out;
    logic             w_emit;
    logic             w_store_we;
    logic             w_step;
    logic             w_last;
    logic [15:0]      w_ticks_inc;
    logic             w_timed_out;
    logic [31:0]      w_words [NUM_WORDS];

    assign o_cmd_ready = !r_out_valid || i_out_ready;
    assign w_step      = i_cmd_valid && o_cmd_ready;
    assign w_last      = (r_count == CNT_W'(PAYLOAD_BYTES - 1));
    assign w_ticks_inc = (r_ticks == 16'hFFFF) ? r_ticks : r_ticks + 16'd1;
    assign w_timed_out = (w_ticks_inc >= i_timeout_ticks);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    for (genvar w = 0; w < NUM_WORDS; w++) begin : g_word
        for (genvar b = 0; b < 4; b++) begin : g_byte
            if (w * 4 + b < PAYLOAD_BYTES) begin : g_have
                assign w_words[w][8*b +: 8] = r_payload[w * 4 + b];
            end else begin : g_zero
                assign w_words[w][8*b +: 8] = 8'h00;
            end
        end
    end

    // next phase
    always_comb begin
        n_phase = r_phase;
        if (w_step) begin
            if (i_cmd.is_tick) begin
                if (r_phase != PH_IDLE && w_timed_out) begin
                    n_phase = PH_IDLE;
                end
            end else begin
                case (r_phase)
                    PH_IDLE:    n_phase = i_cmd.is_start ? PH_MODEL : PH_IDLE;
                    PH_MODEL:   n_phase = PH_PAYLOAD;
                    PH_PAYLOAD: n_phase = w_last ? PH_END : PH_PAYLOAD;
                    PH_END:     n_phase = PH_IDLE;
                    default:    n_phase = PH_IDLE;
                endcase
            end
        end
    end

    // datapath and result
    always_comb begin
        n_count    = r_count;
        n_model    = r_model;
        n_ticks    = r_ticks;
        w_emit     = 1'b0;
        w_store_we = 1'b0;
        n_out      = '0;
        if (w_step) begin
            if (i_cmd.is_tick) begin
                if (r_phase != PH_IDLE) begin
                    if (w_timed_out) begin
                        n_count      = '0;
                        n_ticks      = '0;
                        w_emit       = 1'b1;
                        n_out.status = ST_TIMEOUT;
                    end else begin
                        n_ticks = w_ticks_inc;
                    end
                end
            end else begin
                n_ticks = '0;
                case (r_phase)
                    PH_IDLE: begin
                        if (!i_cmd.is_start) begin
                            w_emit       = 1'b1;
                            n_out.status = ST_BAD_START;
                        end
                    end
                    PH_MODEL: begin
                        n_model = i_cmd.data;
                        n_count = '0;
                    end
                    PH_PAYLOAD: begin
                        w_store_we = 1'b1;
                        n_count    = w_last ? '0 : r_count + CNT_W'(1);
                    end
                    PH_END: begin
                        n_count = '0;
                        w_emit  = 1'b1;
                        if (i_cmd.is_end) begin
                            n_out.status           = ST_OK;
                            n_out.model_code       = r_model;
                            n_out.magnitude_bits   = w_words[0];
                            n_out.phase_bits       = w_words[1];
                            n_out.real_bits        = w_words[2];
                            n_out.imag_bits        = w_words[3];
                            n_out.drive_level_bits = w_words[4];
                            n_out.sense_level_bits = w_words[5];
                            n_out.fit_error_bits   = w_words[6];
                        end else begin
                            n_out.status = ST_BAD_END;
                        end
                    end
                    default: begin
                        n_count = '0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_count     <= '0;
            r_model     <= '0;
            r_ticks     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_count     <= n_count;
            r_model     <= n_model;
            r_ticks     <= n_ticks;
            r_out_valid <= w_emit || (r_out_valid && !i_out_ready);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out <= n_out;
        end
        if (w_store_we) begin
            r_payload[r_count] <= i_cmd.data;
        end
    end

endmodule

`default_nettype wire

### rtl/framed_result_receiver_unit.sv
// top level of the framed result receiver: config registers, front end and back end
`timescale 1ns / 1ps
`default_nettype none

// Byte-wise receiver for marker-delimited result frames. Each input transfer is either
// a received byte or one timer tick; a frame is the start marker, a model byte,
// PAYLOAD_BYTES payload bytes and the end marker, and a good frame yields one result
// with the model byte and seven little-endian 32-bit words. A wrong start byte, a
// wrong end byte or an inter-byte timeout yields one result with an error status and
// zeroed fields. The block takes one item per clock cycle, sustained, as long as
// results are taken; an item waits in a two-entry queue while the frame state
// machine works on it, and its result is loaded into the output register, from
// which it is taken. A stalled output holds the state machine, and the queue then
// fills and holds off the input. Configuration writes are taken in any cycle.
module framed_result_receiver_unit
    import frr_pkg::*;
#(
    parameter int PAYLOAD_BYTES = PAYLOAD_BYTES_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_in_valid,
    output logic                        o_in_ready,
    input  wire t_frr_in                i_in_data,
    output logic                        o_out_valid,
    input  wire logic                   i_out_ready,
    output t_frr_out                    o_out_data,
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_data
);

    logic [15:0] r_timeout_ticks;
    logic [7:0]  r_start_byte;
    logic [7:0]  r_end_byte;
    logic        w_cmd_valid;
    logic        w_cmd_ready;
    t_cmd        w_cmd;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout_ticks <= TIMEOUT_RST;
            r_start_byte    <= START_RST;
            r_end_byte      <= END_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_TIMEOUT: r_timeout_ticks <= i_cfg_data[15:0];
                CFG_START:   r_start_byte    <= i_cfg_data[7:0];
                CFG_END:     r_end_byte      <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    frr_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_data    (i_in_data),
        .i_start_byte (r_start_byte),
        .i_end_byte   (r_end_byte),
        .o_cmd_valid  (w_cmd_valid),
        .i_cmd_ready  (w_cmd_ready),
        .o_cmd        (w_cmd)
    );

    frr_back #(
        .PAYLOAD_BYTES (PAYLOAD_BYTES)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd_valid     (w_cmd_valid),
        .o_cmd_ready     (w_cmd_ready),
        .i_cmd           (w_cmd),
        .i_timeout_ticks (r_timeout_ticks),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_out_data      (o_out_data)
    );

endmodule

`default_nettype wire

### rtl/frr_checker.sv
// port-level checker for the framed result receiver, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module frr_checker
    import frr_pkg::*;
(
    input wire logic     i_clk,
    input wire logic     i_rst_n,
    input wire logic     o_in_ready,
    input wire logic     o_out_valid,
    input wire logic     i_out_ready,
    input wire t_frr_out o_out_data,
    input wire logic     i_cfg_valid,
    input wire logic     o_cfg_ready
);

    `FRR_ASSERT_NEXT(a_out_held, o_out_valid && !i_out_ready, o_out_valid,
        "result dropped while stalled")
    `FRR_ASSERT_NEXT(a_out_stable, o_out_valid && !i_out_ready, $stable(o_out_data),
        "stalled result changed")
    `FRR_ASSERT_IMPL(a_err_zero, o_out_valid && o_out_data.status != ST_OK,
        o_out_data.model_code == 8'h00 && o_out_data.magnitude_bits == 32'h0
        && o_out_data.fit_error_bits == 32'h0,
        "error result carries frame data")
    `FRR_ASSERT_IMPL(a_reset_empty, !$past(i_rst_n), !o_out_valid && o_in_ready,
        "not empty after reset")
    `FRR_ASSERT_IMPL(a_cfg_ready, i_cfg_valid, o_cfg_ready, "config write refused")

endmodule

bind framed_result_receiver_unit frr_checker u_frr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data),
    .i_cfg_valid (i_cfg_valid),
    .o_cfg_ready (o_cfg_ready)
);

`default_nettype wire

### verif/framed_result_receiver_unit_tb.sv
// testbench: framed result receiver unit checked against a frame predictor under random idling
`timescale 1ns / 1ps

module framed_result_receiver_unit_tb;
    import frr_pkg::*;

    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int STALL_LIMIT = 5000;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_in_valid = 1'b0;
    logic                   o_in_ready;
    t_frr_in                i_in_data = '0;
    logic                   o_out_valid;
    logic                   i_out_ready = 1'b0;
    t_frr_out               o_out_data;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_INDEX_W-1:0] i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;

    // frame predictor state
    logic [15:0] cfg_timeout;
    logic [7:0]  cfg_start;
    logic [7:0]  cfg_end;
    t_phase      frame_phase;
    int          payload_idx;
    logic [7:0]  model_byte;
    logic [7:0]  payload_bytes [PAYLOAD_BYTES_DEF];
    logic [15:0] gap_ticks;

    t_frr_out expected_results [$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_off_req = 0;
    int hold_off_seen = 0;
    int hold_left = 0;
    int quiet_cycles = 0;
    int fault_count = 0;
    int items_applied = 0;
    int results_seen = 0;
    int cfg_writes = 0;
    int settings_used = 0;
    int status_tally [4] = '{0, 0, 0, 0};

    framed_result_receiver_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function logic [31:0] payload_word(input int w);
        return {payload_bytes[4*w+3], payload_bytes[4*w+2],
                payload_bytes[4*w+1], payload_bytes[4*w]};
    endfunction

    task predictor_reset();
        cfg_timeout = TIMEOUT_RST;
        cfg_start = START_RST;
        cfg_end = END_RST;
        frame_phase = PH_IDLE;
        payload_idx = 0;
        model_byte = 8'h00;
        gap_ticks = 16'h0000;
    endtask

    task frame_step(input t_frr_in item);
        t_frr_out res;
        bit       emit;
        res = '0;
        emit = 1'b0;
        if (item.func) begin
            if (frame_phase != PH_IDLE) begin
                items_applied++;
                if (gap_ticks != 16'hFFFF)
                    gap_ticks++;
                if (gap_ticks >= cfg_timeout) begin
                    frame_phase = PH_IDLE;
                    payload_idx = 0;
                    gap_ticks = 16'h0000;
                    res.status = ST_TIMEOUT;
                    emit = 1'b1;
                end
            end
        end else begin
            items_applied++;
            gap_ticks = 16'h0000;
            case (frame_phase)
                PH_IDLE: begin
                    if (item.rx_byte == cfg_start) begin
                        frame_phase = PH_MODEL;
                    end else begin
                        res.status = ST_BAD_START;
                        emit = 1'b1;
                    end
                end
                PH_MODEL: begin
                    model_byte = item.rx_byte;
                    payload_idx = 0;
                    frame_phase = PH_PAYLOAD;
                end
                PH_PAYLOAD: begin
                    payload_bytes[payload_idx] = item.rx_byte;
                    payload_idx++;
                    if (payload_idx >= PAYLOAD_BYTES_DEF) begin
                        payload_idx = 0;
                        frame_phase = PH_END;
                    end
                end
                default: begin
                    frame_phase = PH_IDLE;
                    payload_idx = 0;
                    emit = 1'b1;
                    if (item.rx_byte == cfg_end) begin
                        res.status = ST_OK;
                        res.model_code = model_byte;
                        res.magnitude_bits = payload_word(0);
                        res.phase_bits = payload_word(1);
                        res.real_bits = payload_word(2);
                        res.imag_bits = payload_word(3);
                        res.drive_level_bits = payload_word(4);
                        res.sense_level_bits = payload_word(5);
                        res.fit_error_bits = payload_word(6);
                    end else begin
                        res.status = ST_BAD_END;
                    end
                end
            endcase
        end
        if (emit)
            expected_results.push_back(res);
    endtask

    // receiver side: random stalls plus an occasional long hold-off
    always @(posedge i_clk) begin
        if (hold_off_req != hold_off_seen) begin
            hold_off_seen <= hold_off_req;
            hold_left <= HOLD_OFF_CYCLES;
            i_out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task report_field(input string name, input logic [31:0] want, input logic [31:0] have);
        if (have !== want) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, have);
            fault_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_frr_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h",
                         $time, o_out_data);
                fault_count++;
            end else begin
                want = expected_results.pop_front();
                report_field("status", 32'(want.status), 32'(o_out_data.status));
                report_field("model_code", 32'(want.model_code), 32'(o_out_data.model_code));
                report_field("magnitude_bits", want.magnitude_bits, o_out_data.magnitude_bits);
                report_field("phase_bits", want.phase_bits, o_out_data.phase_bits);
                report_field("real_bits", want.real_bits, o_out_data.real_bits);
                report_field("imag_bits", want.imag_bits, o_out_data.imag_bits);
                report_field("drive_level_bits", want.drive_level_bits,
                             o_out_data.drive_level_bits);
                report_field("sense_level_bits", want.sense_level_bits,
                             o_out_data.sense_level_bits);
                report_field("fit_error_bits", want.fit_error_bits,
                             o_out_data.fit_error_bits);
                status_tally[want.status]++;
                results_seen++;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                     $time, STALL_LIMIT, expected_results.size());
            $display("framed_result_receiver_unit_tb: done, errors");
            $finish;
        end
    end

    task send_item(input t_frr_in item);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= item;
        do @(posedge i_clk); while (!o_in_ready);
        frame_step(item);
    endtask

    task send_byte(input logic [7:0] value);
        t_frr_in item;
        item.func = 1'b0;
        item.rx_byte = value;
        send_item(item);
    endtask

    task send_ticks(input int count);
        t_frr_in item;
        for (int i = 0; i < count; i++) begin
            item.func = 1'b1;
            item.rx_byte = 8'($urandom_range(255));
            send_item(item);
        end
    endtask

    // wait until every result is in and the pipeline has emptied
    task settle();
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task write_reg(input t_cfg_index idx, input logic [15:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_TIMEOUT: cfg_timeout = value;
            CFG_START:   cfg_start = value[7:0];
            default:     cfg_end = value[7:0];
        endcase
        cfg_writes++;
        @(posedge i_clk);
    endtask

    task configure(input logic [15:0] timeout, input logic [7:0] start, input logic [7:0] stop);
        settle();
        write_reg(CFG_TIMEOUT, timeout);
        write_reg(CFG_START, {8'h00, start});
        write_reg(CFG_END, {8'h00, stop});
        settings_used++;
    endtask

    task send_plain_frame(input logic [7:0] model, input logic [7:0] fill_base,
                          input int fill_step, input logic [7:0] closing);
        send_byte(cfg_start);
        send_byte(model);
        for (int i = 0; i < PAYLOAD_BYTES_DEF; i++)
            send_byte(8'(int'(fill_base) + i * fill_step));
        send_byte(closing);
    endtask

    function int tick_burst();
        int cap;
        if (cfg_timeout <= 16 && $urandom_range(99) < 4)
            return int'(cfg_timeout);
        cap = (cfg_timeout > 4) ? 3 : int'(cfg_timeout) - 1;
        if (cap < 0)
            cap = 0;
        return $urandom_range(cap, 0);
    endfunction

    task send_random_frame();
        int abort_at;
        abort_at = ($urandom_range(99) < 10) ? $urandom_range(29, 1) : 30;
        send_byte(cfg_start);
        for (int pos = 0; pos < 29 && pos < abort_at; pos++) begin
            if ($urandom_range(99) < 12)
                send_ticks(tick_burst());
            send_byte(8'($urandom_range(255)));
        end
        if (abort_at == 30) begin
            if ($urandom_range(99) < 12)
                send_ticks(tick_burst());
            if ($urandom_range(99) < 85)
                send_byte(cfg_end);
            else
                send_byte(cfg_end ^ 8'($urandom_range(255, 1)));
        end
    endtask

    task test_start_errors();
        send_ticks(1);
        send_byte(8'h00);
        send_byte(8'hFF);
    endtask

    task test_good_frames();
        send_plain_frame(8'h00, 8'h00, 9, cfg_end);
        send_plain_frame(cfg_start, 8'hFF, -9, cfg_end);
    endtask

    // wrong end byte equal to the start marker must not reopen a frame
    task test_bad_end();
        send_plain_frame(8'h3C, 8'h5A, 1, cfg_start);
        send_byte(8'h01);
    endtask

    task test_timeouts();
        settle();
        write_reg(CFG_TIMEOUT, 16'd3);
        send_byte(cfg_start);
        send_byte(8'h77);
        send_byte(8'h12);
        send_ticks(2);
        send_byte(8'h34);
        send_ticks(3);
        send_byte(cfg_end);
        settle();
        write_reg(CFG_TIMEOUT, 16'd0);
        send_byte(cfg_start);
        send_ticks(1);
    endtask

    task test_backpressure();
        settle();
        hold_off_req <= hold_off_req + 1;
        for (int i = 0; i < 40; i++)
            send_byte(cfg_start ^ 8'($urandom_range(255, 1)));
    endtask

    task test_random_traffic(input int count);
        int first;
        int roll;
        first = items_applied;
        while (items_applied - first < count) begin
            roll = $urandom_range(99);
            if (roll < 70)
                send_random_frame();
            else if (roll < 88)
                send_byte(8'($urandom_range(255)));
            else
                send_ticks($urandom_range(4, 1));
        end
    endtask

    initial begin
        predictor_reset();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 20;
        recv_stall_pct = 69;
        test_start_errors();
        test_good_frames();
        test_bad_end();
        test_timeouts();
        test_backpressure();
        configure(16'd7, 8'h3C, 8'hC3);
        test_random_traffic(550);

        send_idle_pct = 69;
        recv_stall_pct = 20;
        configure(16'hFFFF, 8'h00, 8'hFF);
        test_random_traffic(400);
        configure(16'd2, 8'hFF, 8'h00);
        test_random_traffic(300);

        send_idle_pct = 0;
        recv_stall_pct = 0;
        configure(16'd1, 8'h5A, 8'h5A);
        test_random_traffic(250);
        configure(16'd4, 8'hAA, 8'h55);
        test_random_traffic(250);

        settle();
        $display("covered %0d items over %0d settings (%0d register writes), %0d results",
                 items_applied, settings_used + 1, cfg_writes, results_seen);
        $display("results: ok %0d, bad_start %0d, bad_end %0d, timeout %0d",
                 status_tally[ST_OK], status_tally[ST_BAD_START],
                 status_tally[ST_BAD_END], status_tally[ST_TIMEOUT]);
        if (fault_count == 0)
            $display("framed_result_receiver_unit_tb: done, clean");
        else
            $display("framed_result_receiver_unit_tb: done, errors");
        $finish;
    end

endmodule

### filelist.f
+incdir+rtl
rtl/frr_pkg.sv
rtl/frr_front.sv
rtl/frr_back.sv
rtl/framed_result_receiver_unit.sv
rtl/frr_checker.sv
verif/framed_result_receiver_unit_tb.sv
